[rtl/oots_pkg.sv]
// Shared types, codes and timing constants of the on/off server timer.
`default_nettype none

package oots_pkg;

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_SET_UNACK = 2'd1,
    REQ_SET_ACK   = 2'd2,
    REQ_GET       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RES_100MS = 2'd0,
    RES_1S    = 2'd1,
    RES_10S   = 2'd2,
    RES_10MIN = 2'd3
  } res_t;

  typedef logic [25:0] cnt_t;

  localparam logic [5:0] STEP_MASK    = 6'h3f;
  localparam logic [7:0] CODE_UNKNOWN = 8'h3f;
  localparam int unsigned STEPS_MAX   = 62;
  localparam int unsigned DELAY_UNIT  = 5;

  localparam cnt_t RES_MS [4] = '{
    cnt_t'(100), cnt_t'(1000), cnt_t'(10000), cnt_t'(600000)
  };

  localparam cnt_t RES_LIMIT [4] = '{
    cnt_t'(STEPS_MAX * 100), cnt_t'(STEPS_MAX * 1000),
    cnt_t'(STEPS_MAX * 10000), cnt_t'(STEPS_MAX * 600000)
  };

  // reciprocal shift: counter width plus bits of the divisor
  localparam int unsigned RES_SHIFT [4] = '{33, 36, 40, 46};

  localparam logic [26:0] RES_RECIP [4] = '{
    27'(((64'd1 << 33) + 64'd99) / 64'd100),
    27'(((64'd1 << 36) + 64'd999) / 64'd1000),
    27'(((64'd1 << 40) + 64'd9999) / 64'd10000),
    27'(((64'd1 << 46) + 64'd599999) / 64'd600000)
  };

  typedef struct packed {
    logic [1:0]  req_type;
    logic        new_value;
    logic [7:0]  trans_id;
    logic [15:0] src_addr;
    logic        has_timing;
    logic [7:0]  trans_code;
    logic [7:0]  delay_code;
  } req_beat_t;

  typedef struct packed {
    logic       led_on;
    logic       status_valid;
    logic       present_value;
    logic       has_remaining;
    logic       target_value;
    logic [7:0] remaining_code;
  } rsp_beat_t;

  typedef struct packed {
    logic led;
    logic status;
    logic busy;
    logic endless;
    logic target;
    cnt_t sum;
  } snap_t;

  function automatic cnt_t trans_ms(input logic [5:0] steps, input res_t res);
    trans_ms = cnt_t'(steps) * RES_MS[res];
  endfunction

endpackage

`default_nettype wire

[rtl/oots_timer.sv]
// Server state: duplicate filter, delay and transition countdown, LED level.
`default_nettype none

module oots_timer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire oots_pkg::req_beat_t beat,
  output oots_pkg::snap_t        snap
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_TRANS = 2'd2
  } phase_t;

  phase_t         phase, phase_next;
  logic           target_state, target_state_next;
  logic [7:0]     prev_tid, prev_tid_next;
  logic [15:0]    prev_src, prev_src_next;
  oots_pkg::cnt_t pending, pending_next;
  oots_pkg::cnt_t countdown, countdown_next;
  logic           forever_flag, forever_flag_next;
  logic           led_level, led_level_next;
  logic [7:0]     tcode, dcode;
  logic           busy_next;

  always_comb begin
    phase_next        = phase;
    target_state_next = target_state;
    prev_tid_next     = prev_tid;
    prev_src_next     = prev_src;
    pending_next      = pending;
    countdown_next    = countdown;
    forever_flag_next = forever_flag;
    led_level_next    = led_level;
    tcode = beat.has_timing ? beat.trans_code : 8'd0;
    dcode = beat.has_timing ? beat.delay_code : 8'd0;
    case (beat.req_type)
      oots_pkg::REQ_TICK: begin
        case (phase)
          PH_DELAY: begin
            if (countdown <= oots_pkg::cnt_t'(1)) begin
              if (pending != '0 || forever_flag) begin
                led_level_next = 1'b1;
                phase_next     = PH_TRANS;
                countdown_next = pending;
                pending_next   = '0;
              end else begin
                led_level_next = target_state;
                phase_next     = PH_IDLE;
                countdown_next = '0;
              end
            end else begin
              countdown_next = countdown - oots_pkg::cnt_t'(1);
            end
          end
          PH_TRANS: begin
            if (!forever_flag) begin
              if (countdown <= oots_pkg::cnt_t'(1)) begin
                led_level_next = target_state;
                phase_next     = PH_IDLE;
                countdown_next = '0;
              end else begin
                countdown_next = countdown - oots_pkg::cnt_t'(1);
              end
            end
          end
          default: ;
        endcase
      end
      oots_pkg::REQ_SET_UNACK, oots_pkg::REQ_SET_ACK: begin
        if (!(beat.trans_id == prev_tid && beat.src_addr == prev_src) &&
            beat.new_value != target_state) begin
          if (tcode[5:0] == oots_pkg::STEP_MASK) begin
            forever_flag_next = 1'b1;
            pending_next      = '0;
          end else begin
            forever_flag_next = 1'b0;
            pending_next      = oots_pkg::trans_ms(tcode[5:0], oots_pkg::res_t'(tcode[7:6]));
          end
          prev_tid_next     = beat.trans_id;
          prev_src_next     = beat.src_addr;
          target_state_next = beat.new_value;
          countdown_next    = oots_pkg::cnt_t'(dcode) *
                              oots_pkg::cnt_t'(oots_pkg::DELAY_UNIT);
          phase_next        = PH_DELAY;
        end
      end
      default: ;
    endcase
  end

  assign busy_next = (phase_next == PH_DELAY) || (phase_next == PH_TRANS);

  always_comb begin
    snap.led     = led_level_next;
    snap.status  = (beat.req_type == oots_pkg::REQ_SET_ACK) ||
                   (beat.req_type == oots_pkg::REQ_GET);
    snap.busy    = busy_next;
    snap.endless = forever_flag_next;
    snap.target  = target_state_next;
    snap.sum     = busy_next ? countdown_next + pending_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      target_state <= 1'b0;
      prev_tid     <= '0;
      prev_src     <= '0;
      pending      <= '0;
      countdown    <= '0;
      forever_flag <= 1'b0;
      led_level    <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      target_state <= target_state_next;
      prev_tid     <= prev_tid_next;
      prev_src     <= prev_src_next;
      pending      <= pending_next;
      countdown    <= countdown_next;
      forever_flag <= forever_flag_next;
      led_level    <= led_level_next;
    end
  end

endmodule

`default_nettype wire

[rtl/oots_encode.sv]
// Remaining-time encoder: resolution pick and rounded-up step count.
`default_nettype none

module oots_encode (
  input  wire oots_pkg::cnt_t sum,
  output logic [7:0]          code
);

  oots_pkg::cnt_t  x;
  oots_pkg::res_t  res;
  logic            fits;
  logic [52:0]     prod;
  logic [5:0]      q;

  always_comb begin
    x    = sum - oots_pkg::cnt_t'(1);
    res  = oots_pkg::RES_10MIN;
    fits = 1'b1;
    if (sum <= oots_pkg::RES_LIMIT[oots_pkg::RES_100MS]) begin
      res = oots_pkg::RES_100MS;
    end else if (sum <= oots_pkg::RES_LIMIT[oots_pkg::RES_1S]) begin
      res = oots_pkg::RES_1S;
    end else if (sum <= oots_pkg::RES_LIMIT[oots_pkg::RES_10S]) begin
      res = oots_pkg::RES_10S;
    end else if (sum > oots_pkg::RES_LIMIT[oots_pkg::RES_10MIN]) begin
      fits = 1'b0;
    end
    prod = 53'(x) * 53'(oots_pkg::RES_RECIP[res]);
    case (res)
      oots_pkg::RES_100MS: q = prod[oots_pkg::RES_SHIFT[0] +: 6];
      oots_pkg::RES_1S:    q = prod[oots_pkg::RES_SHIFT[1] +: 6];
      oots_pkg::RES_10S:   q = prod[oots_pkg::RES_SHIFT[2] +: 6];
      default:             q = prod[oots_pkg::RES_SHIFT[3] +: 6];
    endcase
    code = fits ? {res, q + 6'd1} : oots_pkg::CODE_UNKNOWN;
  end

endmodule

`default_nettype wire

[rtl/onoff_server_transition_timer.sv]
// Generic on/off server with delay and transition timing on 1 ms ticks.
// A taken request beat is registered in s1, then its result beat in rsp; rsp_stall can hold it in s1.
// One request beat per cycle while req_stall is low; the next server state is combinational.
// The remaining-time encoder sits in the second stage, one 26x27 multiply.
// Reset: synchronous; clears all server state and empties both stages.
`default_nettype none

module onoff_server_transition_timer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire oots_pkg::req_beat_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output oots_pkg::rsp_beat_t      rsp
);

  logic                accept;
  logic                load_out;
  logic                s1_valid;
  oots_pkg::snap_t     snap;
  oots_pkg::snap_t     s1;
  logic [7:0]          enc_code;
  oots_pkg::rsp_beat_t rsp_next;

  assign load_out  = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !load_out;
  assign accept    = req_valid && !req_stall;

  oots_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (req),
    .snap   (snap)
  );

  oots_encode u_encode (
    .sum  (s1.sum),
    .code (enc_code)
  );

  always_comb begin
    rsp_next        = '0;
    rsp_next.led_on = s1.led;
    if (s1.status) begin
      rsp_next.status_valid = 1'b1;
      if (s1.busy && s1.endless) begin
        rsp_next.present_value  = !s1.target;
        rsp_next.has_remaining  = 1'b1;
        rsp_next.target_value   = s1.target;
        rsp_next.remaining_code = oots_pkg::CODE_UNKNOWN;
      end else if (s1.sum != '0) begin
        rsp_next.present_value  = !s1.target;
        rsp_next.has_remaining  = 1'b1;
        rsp_next.target_value   = s1.target;
        rsp_next.remaining_code = enc_code;
      end else begin
        rsp_next.present_value  = s1.target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end
      if (load_out) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= snap;
    end
    if (load_out && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

[rtl/oots_checker.sv]
// Port checker for the on/off server timer, bound to the top level.
`default_nettype none

module oots_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire oots_pkg::rsp_beat_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_no_status_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.status_valid |->
      !rsp.present_value && !rsp.has_remaining && !rsp.target_value &&
      rsp.remaining_code == 8'd0)
    else $error("status fields set without a status");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_remaining |->
      !rsp.target_value && rsp.remaining_code == 8'd0)
    else $error("target or remaining time without a pending change");

  a_pending_differs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_remaining |->
      rsp.status_valid && rsp.present_value != rsp.target_value)
    else $error("pending change reports present equal to target");

  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_remaining && rsp.remaining_code != oots_pkg::CODE_UNKNOWN |->
      rsp.remaining_code[5:0] != 6'd0 && rsp.remaining_code[5:0] <= 6'd62)
    else $error("remaining step count out of range");

endmodule

bind onoff_server_transition_timer oots_checker u_oots_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
